// ===== hdl/lsac_pkg.sv =====
// ----------------------------------------------------------------------------
// lsac_pkg: shared types and constants for the longest segment block
// Holds field widths, the bitmap word geometry and the structs that pass
// between the sequencer, the bit search unit and the register block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsac_pkg;

  // Width of every length and position field on the ports.
  localparam int LEN_W  = 11;
  // The cut bitmap is stored and scanned one word at a time.
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Register index of bar_length (taken from paddr[2]).
  localparam logic REG_BAR_LENGTH = 1'b0;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BIT_W-1:0]  bit_idx_t;

  // Request to the bit search unit.
  typedef struct packed {
    word_t    word;   // bitmap word to search
    bit_idx_t lim;    // search strictly below (down) or above (up) this bit
    logic     whole;  // ignore lim and search the whole word
    logic     up;     // 1: lowest set bit above lim, 0: highest set bit below
  } find_req_t;

  // Answer of the bit search unit.
  typedef struct packed {
    logic     found;
    bit_idx_t idx;
  } find_rsp_t;

  // Status from the register block to the sequencer.
  typedef struct packed {
    logic restore;  // bar_length written this cycle
    len_t len;      // effective bar length, clamped
  } cfg_stat_t;

endpackage : lsac_pkg

`default_nettype wire

// ===== hdl/lsac_chan_if.sv =====
// ----------------------------------------------------------------------------
// lsac_chan_if: valid/ready channels of the longest segment block
// lsac_in_if carries cut beats, lsac_out_if carries result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsac_in_if
  import lsac_pkg::*;
  ();
  logic valid;
  logic ready;
  len_t cut_position;
  logic start_new;

  modport source (output valid, output cut_position, output start_new, input ready);
  modport sink   (input valid, input cut_position, input start_new, output ready);
endinterface : lsac_in_if

interface lsac_out_if
  import lsac_pkg::*;
  ();
  logic valid;
  logic ready;
  len_t longest_piece;
  logic rejected;

  modport source (output valid, output longest_piece, output rejected, input ready);
  modport sink   (input valid, input longest_piece, input rejected, output ready);
endinterface : lsac_out_if

`default_nettype wire

// ===== hdl/lsac_bit_find.sv =====
// ----------------------------------------------------------------------------
// lsac_bit_find: nearest set bit search within one bitmap word
// Finds the highest set bit below a limit or the lowest set bit above it,
// or over the whole word. Shared by the left and right neighbor scans.
// ----------------------------------------------------------------------------
`default_nettype none

module lsac_bit_find
  import lsac_pkg::*;
(
  input  find_req_t req,
  output find_rsp_t rsp
);

  // Qualify each bit, then keep the last hit in search order.
  always_comb begin
    logic     hit;
    bit_idx_t pos;
    logic     in_range;
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (req.up) begin
        // Walk downward so that the lowest qualifying bit wins.
        in_range = req.whole || (bit_idx_t'(WORD_W - 1 - i) > req.lim);
        if (in_range && req.word[WORD_W-1-i]) begin
          hit = 1'b1;
          pos = bit_idx_t'(WORD_W - 1 - i);
        end
      end else begin
        // Walk upward so that the highest qualifying bit wins.
        in_range = req.whole || (bit_idx_t'(i) < req.lim);
        if (in_range && req.word[i]) begin
          hit = 1'b1;
          pos = bit_idx_t'(i);
        end
      end
    end
    rsp.found = hit;
    rsp.idx   = pos;
  end

endmodule : lsac_bit_find

`default_nettype wire

// ===== hdl/lsac_cfg.sv =====
// ----------------------------------------------------------------------------
// lsac_cfg: APB register block for the bar length
// Holds bar_length, clamps it to the supported range and signals a restore
// of the whole bar whenever it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module lsac_cfg
  import lsac_pkg::*;
#(
  parameter int LEN_MAX = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_stat_t        stat
);

  localparam len_t LenMax   = len_t'(LEN_MAX);
  localparam len_t LenReset = len_t'(1024);

  len_t bar_length_r;
  logic wr_bar;

  assign pready = 1'b1;
  assign wr_bar = psel && penable && pwrite && (paddr[2] == REG_BAR_LENGTH);

  // Register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_length_r <= LenReset;
    end else if (wr_bar) begin
      bar_length_r <= pwdata[LEN_W-1:0];
    end
  end

  // Read back; other addresses read as zero.
  assign prdata = (paddr[2] == REG_BAR_LENGTH) ? 32'(bar_length_r) : 32'd0;

  // Effective length: zero acts as one, values above the limit saturate.
  always_comb begin
    stat.restore = wr_bar;
    if (bar_length_r == '0) begin
      stat.len = len_t'(1);
    end else if (bar_length_r > LenMax) begin
      stat.len = LenMax;
    end else begin
      stat.len = bar_length_r;
    end
  end

endmodule : lsac_cfg

`default_nettype wire

// ===== hdl/longest_segment_after_cuts.sv =====
// Steps: a range check, a bitmap read, the left and right neighbor scans word
// by word, three count updates and the downward maximum scan; a repeated cut
// skips from the bitmap read to the result, a rejected one from the range check.
// One item at a time: the next beat is taken once the result is registered.
// Reset, a bar_length write and a start_new beat first run a clearing pass.
// ----------------------------------------------------------------------------
// longest_segment_after_cuts: longest piece of a bar after each cut
// Keeps a cut bitmap and a per-length piece count table in memories. A
// sequencer scans the bitmap word by word through a shared bit search unit
// for the neighbors of a new cut, updates three counts and walks the longest
// length downward until a nonzero count is found.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_segment_after_cuts
  import lsac_pkg::*;
#(
  parameter int MAX_LENGTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lsac_in_if.sink          in_ch,
  lsac_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Lengths cannot exceed what the 11-bit fields carry.
  localparam int LEN_TOP = (1 << LEN_W) - 1;
  localparam int DEPTH   = ((MAX_LENGTH < LEN_TOP) ? MAX_LENGTH : LEN_TOP) + 1;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int WAW     = (NW > 1) ? $clog2(NW) : 1;

  typedef logic [AW-1:0]  addr_t;
  typedef logic [WAW-1:0] waddr_t;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_CHECK, S_MARK, S_LSCAN, S_RSCAN,
    S_CRD, S_CWR, S_MRD, S_MCHK, S_DONE
  } state_t;

  // Count update steps.
  localparam logic [1:0] STEP_TOTAL = 2'd0;
  localparam logic [1:0] STEP_LEFT  = 2'd1;
  localparam logic [1:0] STEP_RIGHT = 2'd2;

  cfg_stat_t cfg_stat;
  find_req_t find_req;
  find_rsp_t find_rsp;

  state_t     state_r;
  addr_t      idx_r;
  logic       pend_r;
  len_t       pos_r;
  logic       rej_r;
  waddr_t     word_r;
  logic       first_r;
  addr_t      lo_r;
  addr_t      hi_r;
  logic [1:0] step_r;
  addr_t      cur_r;
  logic       ov_r;
  len_t       olong_r;
  logic       orej_r;
  logic       done_fire;

  // Memory ports.
  word_t  mark_mem [NW];
  addr_t  cnt_mem  [DEPTH];
  waddr_t mk_raddr;
  word_t  mk_rdata_r;
  logic   mk_we;
  waddr_t mk_waddr;
  word_t  mk_wdata;
  addr_t  ct_raddr;
  addr_t  ct_rdata_r;
  logic   ct_we;
  addr_t  ct_waddr;
  addr_t  ct_wdata;

  // Derived positions.
  addr_t    len_a;
  addr_t    pos_a;
  waddr_t   pos_word;
  bit_idx_t pos_bit;
  waddr_t   len_word;
  bit_idx_t len_bit;
  addr_t    left_len;
  addr_t    right_len;
  addr_t    total_len;
  addr_t    cnt_addr;
  addr_t    found_pos;

  lsac_cfg #(
    .LEN_MAX (DEPTH - 1)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stat    (cfg_stat)
  );

  lsac_bit_find u_find (
    .req (find_req),
    .rsp (find_rsp)
  );

  assign len_a     = addr_t'(cfg_stat.len);
  assign pos_a     = addr_t'(pos_r);
  assign pos_word  = waddr_t'(pos_a >> BIT_W);
  assign pos_bit   = bit_idx_t'(pos_a);
  assign len_word  = waddr_t'(len_a >> BIT_W);
  assign len_bit   = bit_idx_t'(len_a);
  assign left_len  = pos_a - lo_r;
  assign right_len = hi_r - pos_a;
  assign total_len = hi_r - lo_r;
  assign found_pos = addr_t'({word_r, find_rsp.idx});

  // A finished result moves into the output register once it is free.
  assign done_fire = (state_r == S_DONE) && (!ov_r || out_ch.ready);

  // Count table address of the current update step.
  always_comb begin
    case (step_r)
      STEP_TOTAL: cnt_addr = total_len;
      STEP_LEFT:  cnt_addr = left_len;
      default:    cnt_addr = right_len;
    endcase
  end

  // Search request: down for the left neighbor, up for the right one.
  always_comb begin
    find_req.word  = mk_rdata_r;
    find_req.lim   = pos_bit;
    find_req.whole = !first_r;
    find_req.up    = (state_r == S_RSCAN);
  end

  // Memory addressing and write data per state.
  always_comb begin
    mk_raddr = pos_word;
    mk_we    = 1'b0;
    mk_waddr = pos_word;
    mk_wdata = mk_rdata_r | (word_t'(1) << pos_bit);
    ct_raddr = cnt_addr;
    ct_we    = 1'b0;
    ct_waddr = cnt_addr;
    ct_wdata = ct_rdata_r + addr_t'(1);
    case (state_r)
      S_SWEEP: begin
        // Clear both tables, marking the two ends and counting the whole bar.
        mk_we    = (32'(idx_r) < NW);
        mk_waddr = waddr_t'(idx_r);
        mk_wdata = ((idx_r == '0) ? word_t'(1) : '0) |
                   ((waddr_t'(idx_r) == len_word) ? (word_t'(1) << len_bit) : '0);
        ct_we    = 1'b1;
        ct_waddr = idx_r;
        ct_wdata = (idx_r == len_a) ? addr_t'(1) : '0;
      end
      S_MARK: begin
        mk_we = !mk_rdata_r[pos_bit];
      end
      S_LSCAN: begin
        mk_raddr = find_rsp.found ? pos_word : (word_r - waddr_t'(1));
      end
      S_RSCAN: begin
        mk_raddr = word_r + waddr_t'(1);
      end
      S_CWR: begin
        ct_we = 1'b1;
        if (step_r == STEP_TOTAL) begin
          ct_wdata = (ct_rdata_r != '0) ? (ct_rdata_r - addr_t'(1)) : ct_rdata_r;
        end
      end
      S_MRD: begin
        ct_raddr = cur_r;
      end
      default: begin
      end
    endcase
  end

  // Cut bitmap memory.
  always_ff @(posedge clk) begin
    mk_rdata_r <= mark_mem[mk_raddr];
    if (mk_we) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
  end

  // Piece count memory.
  always_ff @(posedge clk) begin
    ct_rdata_r <= cnt_mem[ct_raddr];
    if (ct_we) begin
      cnt_mem[ct_waddr] <= ct_wdata;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      // The output register loads a finished result or empties when taken.
      if (done_fire) begin
        ov_r    <= 1'b1;
        olong_r <= len_t'(cur_r);
        orej_r  <= rej_r;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_stat.restore) begin
        // A bar_length write restores the whole bar.
        idx_r   <= '0;
        state_r <= S_SWEEP;
      end else begin
        case (state_r)
          S_SWEEP: begin
            if (idx_r == addr_t'(DEPTH - 1)) begin
              cur_r   <= len_a;
              pend_r  <= 1'b0;
              state_r <= pend_r ? S_CHECK : S_IDLE;
            end else begin
              idx_r <= idx_r + addr_t'(1);
            end
          end
          S_IDLE: begin
            if (in_ch.valid) begin
              pos_r <= in_ch.cut_position;
              if (in_ch.start_new) begin
                idx_r   <= '0;
                pend_r  <= 1'b1;
                state_r <= S_SWEEP;
              end else begin
                state_r <= S_CHECK;
              end
            end
          end
          S_CHECK: begin
            rej_r   <= (pos_r > cfg_stat.len);
            state_r <= (pos_r > cfg_stat.len) ? S_DONE : S_MARK;
          end
          S_MARK: begin
            // A cut already present changes nothing.
            if (mk_rdata_r[pos_bit]) begin
              state_r <= S_DONE;
            end else begin
              word_r  <= pos_word;
              first_r <= 1'b1;
              state_r <= S_LSCAN;
            end
          end
          S_LSCAN: begin
            if (find_rsp.found) begin
              lo_r    <= found_pos;
              word_r  <= pos_word;
              first_r <= 1'b1;
              state_r <= S_RSCAN;
            end else begin
              word_r  <= word_r - waddr_t'(1);
              first_r <= 1'b0;
            end
          end
          S_RSCAN: begin
            if (find_rsp.found) begin
              hi_r    <= found_pos;
              step_r  <= STEP_TOTAL;
              state_r <= S_CRD;
            end else begin
              word_r  <= word_r + waddr_t'(1);
              first_r <= 1'b0;
            end
          end
          S_CRD: begin
            state_r <= S_CWR;
          end
          S_CWR: begin
            if (step_r == STEP_RIGHT) begin
              state_r <= S_MRD;
            end else begin
              step_r  <= step_r + 2'd1;
              state_r <= S_CRD;
            end
          end
          S_MRD: begin
            state_r <= S_MCHK;
          end
          S_MCHK: begin
            // The longest length only falls, so walk down to a nonzero count.
            if (cur_r == '0 || ct_rdata_r != '0) begin
              state_r <= S_DONE;
            end else begin
              cur_r   <= cur_r - addr_t'(1);
              state_r <= S_MRD;
            end
          end
          S_DONE: begin
            if (done_fire) begin
              state_r <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  // No cut is taken in the cycle that bar_length is written.
  assign in_ch.ready          = (state_r == S_IDLE) && !cfg_stat.restore;
  assign out_ch.valid         = ov_r;
  assign out_ch.longest_piece = olong_r;
  assign out_ch.rejected      = orej_r;

endmodule : longest_segment_after_cuts

`default_nettype wire

// ===== hdl/lsac_checker.sv =====
// ----------------------------------------------------------------------------
// lsac_checker: port-level checks for longest_segment_after_cuts
// Watches the channels and the register port and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsac_checker
  import lsac_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire len_t longest_piece,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic pready,
  input wire logic paddr_hi
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // One cut at a time: the block is busy right after taking a beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("cut beat taken while the previous one is in work");

  // Writing bar_length starts a clearing pass that holds off new cuts.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr_hi == REG_BAR_LENGTH) |=> !in_ready)
    else $error("cut accepted during the clearing pass");

  // Some piece always remains, so the longest piece is never zero.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> longest_piece != '0)
    else $error("longest piece reported as zero");

endmodule : lsac_checker

bind longest_segment_after_cuts lsac_checker u_lsac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .longest_piece (out_ch.longest_piece),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .pready        (pready),
  .paddr_hi      (paddr[2])
);

`default_nettype wire
